// ----- design/ste_pkg.sv -----
// shared types and constants for the staggered trapezoid envelope
`default_nettype none
package ste_pkg;

  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned START_W = 13;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef logic [LVL_W-1:0] level_t;

  localparam level_t LEVEL_FULL = 16'hFF00;

  localparam logic [MS_W-1:0]  RISE_RST   = 10'd100;
  localparam logic [MS_W-1:0]  HOLD_RST   = 10'd220;
  localparam logic [MS_W-1:0]  ONSET_RST  = 10'd110;
  localparam logic [15:0]      STEP_RST   = 16'd653;
  localparam logic [CNT_W-1:0] PERIOD_RST = 16'd2000;

  typedef enum logic [2:0] {
    REG_RISE   = 3'd0,
    REG_HOLD   = 3'd1,
    REG_ONSET  = 3'd2,
    REG_STEP   = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MS_W-1:0]  rise_ms;
    logic [MS_W-1:0]  hold_ms;
    logic [MS_W-1:0]  onset_ms;
    logic [15:0]      step_q8;
    logic [CNT_W-1:0] period_ms;
  } cfg_t;

endpackage
`default_nettype wire

// ----- design/ste_if.sv -----
// stream interfaces for the tick input and the level result
`default_nettype none
interface ste_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ste_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level_first;
  logic [7:0] level_second;
  logic [7:0] level_third;
  logic [7:0] level_fourth;
  modport source (output valid, output level_first, output level_second,
                  output level_third, output level_fourth, input ready);
  modport sink   (input valid, input level_first, input level_second,
                  input level_third, input level_fourth, output ready);
endinterface
`default_nettype wire

// ----- design/ste_cfg_regs.sv -----
// apb register file for the envelope timing and step settings
`default_nettype none
module ste_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ste_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [ste_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [ste_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output ste_pkg::cfg_t             cfg
);
  import ste_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_ms   <= RISE_RST;
      cfg_r.hold_ms   <= HOLD_RST;
      cfg_r.onset_ms  <= ONSET_RST;
      cfg_r.step_q8   <= STEP_RST;
      cfg_r.period_ms <= PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_RISE:   cfg_r.rise_ms   <= cfg_pwdata[MS_W-1:0];
        REG_HOLD:   cfg_r.hold_ms   <= cfg_pwdata[MS_W-1:0];
        REG_ONSET:  cfg_r.onset_ms  <= cfg_pwdata[MS_W-1:0];
        REG_STEP:   cfg_r.step_q8   <= cfg_pwdata[15:0];
        REG_PERIOD: cfg_r.period_ms <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RISE:   cfg_prdata = DATA_W'(cfg_r.rise_ms);
      REG_HOLD:   cfg_prdata = DATA_W'(cfg_r.hold_ms);
      REG_ONSET:  cfg_prdata = DATA_W'(cfg_r.onset_ms);
      REG_STEP:   cfg_prdata = DATA_W'(cfg_r.step_q8);
      REG_PERIOD: cfg_prdata = DATA_W'(cfg_r.period_ms);
      default:    cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/ste_channel.sv -----
// next-level logic for one channel's trapezoid
`default_nettype none
module ste_channel (
  input  ste_pkg::cfg_t                cfg,
  input  logic [ste_pkg::CNT_W-1:0]    now,
  input  logic [ste_pkg::START_W-1:0]  start,
  input  ste_pkg::level_t              level,
  output ste_pkg::level_t              level_nxt
);
  import ste_pkg::*;

  logic [CNT_W-1:0] rel;
  logic [10:0]      hold_end;
  logic [11:0]      fall_end;
  logic [LVL_W:0]   sum;
  level_t           up;
  level_t           down;

  assign rel      = now - CNT_W'(start);
  assign hold_end = {1'b0, cfg.rise_ms} + {1'b0, cfg.hold_ms};
  assign fall_end = {1'b0, hold_end} + {2'b0, cfg.rise_ms};

  // saturating add, flooring subtract
  assign sum  = {1'b0, level} + {1'b0, cfg.step_q8};
  assign up   = (sum >= {1'b0, LEVEL_FULL}) ? LEVEL_FULL : sum[LVL_W-1:0];
  assign down = (level > cfg.step_q8) ? (level - cfg.step_q8) : '0;

  always_comb begin
    if (now < CNT_W'(start)) begin
      level_nxt = '0;
    end else if (rel < CNT_W'(cfg.rise_ms)) begin
      level_nxt = up;
    end else if (rel < CNT_W'(hold_end)) begin
      level_nxt = LEVEL_FULL;
    end else if (rel < CNT_W'(fall_end)) begin
      level_nxt = down;
    end else begin
      level_nxt = '0;
    end
  end

endmodule
`default_nettype wire

// ----- design/staggered_trapezoid_envelope.sv -----
// top level: four-channel staggered trapezoid envelope with apb settings
//
//   channel  dir  payload                                   handshake
//   in_ch    in   tick                                      valid/ready
//   out_ch   out  level_first..level_fourth (8 bits each)   valid/ready
//   cfg_*    in   apb write/read of five config registers   psel/penable
//
// one beat in gives one beat out in the cycle after; a beat is taken every cycle
// while the result register is empty or being drained. the channel levels are
// the result register itself, so a stalled result holds in_ch off.
// rst_n (synchronous) clears the period count, the levels and out valid, and
// loads the register defaults.
`default_nettype none
module staggered_trapezoid_envelope (
  input  logic                       clk,
  input  logic                       rst_n,
  ste_in_if.sink                     in_ch,
  ste_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ste_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [ste_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [ste_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ste_pkg::*;

  cfg_t             cfg;
  logic             in_acc;
  logic             step_en;
  logic             out_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W:0]   cnt_inc;
  logic [MS_W:0]    spacing;
  logic [START_W-1:0] start [NUM_CH];
  level_t           level_r   [NUM_CH];
  level_t           level_nxt [NUM_CH];

  ste_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign step_en     = in_acc && in_ch.tick;

  assign spacing = {1'b0, cfg.rise_ms} + {1'b0, cfg.onset_ms};

  genvar k;
  generate
    for (k = 0; k < NUM_CH; k++) begin : g_ch
      assign start[k] = START_W'(k) * START_W'(spacing);
      ste_channel u_ch (
        .cfg       (cfg),
        .now       (cnt_r),
        .start     (start[k]),
        .level     (level_r[k]),
        .level_nxt (level_nxt[k])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          level_r[k] <= '0;
        end else if (step_en) begin
          level_r[k] <= level_nxt[k];
        end
      end
    end
  endgenerate

  // wrap also covers a zero period and a period lowered below the count
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign cnt_nxt = (cnt_inc >= {1'b0, cfg.period_ms}) ? '0 : cnt_inc[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step_en) begin
        cnt_r <= cnt_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level_first  = level_r[0][LVL_W-1 -: OUT_W];
  assign out_ch.level_second = level_r[1][LVL_W-1 -: OUT_W];
  assign out_ch.level_third  = level_r[2][LVL_W-1 -: OUT_W];
  assign out_ch.level_fourth = level_r[3][LVL_W-1 -: OUT_W];

  a_stall_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_idle_beat_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.tick) |=> ($stable(cnt_r) && $stable(level_r[0]) &&
      $stable(level_r[1]) && $stable(level_r[2]) && $stable(level_r[3])))
    else $error("state moved on a beat without tick");

  a_count_wraps : assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> ((cnt_r == '0) || (cnt_r < $past(cfg.period_ms))))
    else $error("period count past period");

  a_level_cap : assert property (@(posedge clk) disable iff (!rst_n)
    (level_r[0] <= LEVEL_FULL) && (level_r[1] <= LEVEL_FULL) &&
    (level_r[2] <= LEVEL_FULL) && (level_r[3] <= LEVEL_FULL))
    else $error("channel level above full scale");

endmodule
`default_nettype wire
